// File: hdl/srw_pkg.sv
`default_nettype none
package srw_pkg;

    // Fixed geometry
    localparam int unsigned SEG_BYTES   = 1000;
    localparam int unsigned SLOTS       = 32;
    localparam int unsigned SLOT_W      = $clog2(SLOTS);
    localparam int unsigned FRAME_W     = 32;
    localparam int unsigned LEN_W       = 10;
    localparam int unsigned REM_W       = $clog2(SEG_BYTES);
    localparam int unsigned MAX_RESULTS = 64;

    // Reciprocal of SEG_BYTES, rounded up, scaled by 2^RECIP_SH
    localparam int unsigned RECIP_SH = 31 + REM_W;
    localparam logic [31:0] RECIP    =
        32'(((64'd1 << RECIP_SH) + 64'(SEG_BYTES) - 64'd1) / 64'(SEG_BYTES));

    // Input operation codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_DELIV = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;

    // Register indexes
    localparam logic REG_FILE_BYTES = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [31:0]       seg_offset;
        logic [LEN_W-1:0]  seg_length;
    } in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       frame_offset;
        logic [LEN_W-1:0]  frame_length;
        logic              last_of_run;
        logic              transfer_done;
    } out_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic                is_arrival;
        logic                aligned;
        logic [FRAME_W-1:0]  frame;
        logic [LEN_W-1:0]    length;
    } cmd_t;

    // Settings derived from the registers
    typedef struct packed {
        logic [FRAME_W-1:0]  eof_frame;
        logic [LEN_W-1:0]    last_len;
        logic [31:0]         timeout;
    } cfg_t;

endpackage
`default_nettype wire

// File: hdl/srw_div.sv
`default_nettype none
// Divide by SEG_BYTES through a reciprocal multiply; done pulses once the start
// edge has taken the unit through its D_MUL and D_REM states
module srw_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [31:0]                       dividend,
    output logic                                   busy,
    output logic                                   done,
    output logic [31:0]                            quot,
    output logic [srw_pkg::REM_W-1:0]              rem
);
    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_REM  = 2'd2;

    logic [1:0]                   stage_reg, stage_next;
    logic                         done_reg, done_next;
    logic [31:0]                  dvd_reg, dvd_next;
    logic [63:0]                  prod_reg, prod_next;
    logic [31:0]                  quot_reg, quot_next;
    logic [srw_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [31:0]                  q_est;

    // Multiply, then take quotient and remainder
    always_comb
    begin
        q_est      = 32'(prod_reg >> srw_pkg::RECIP_SH);
        stage_next = stage_reg;
        done_next  = 1'b0;
        dvd_next   = dvd_reg;
        prod_next  = prod_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        unique case (stage_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = dividend;
                    stage_next = D_MUL;
                end
            end
            D_MUL:
            begin
                prod_next  = 64'(dvd_reg) * 64'(srw_pkg::RECIP);
                stage_next = D_REM;
            end
            D_REM:
            begin
                quot_next  = q_est;
                rem_next   = srw_pkg::REM_W'(dvd_reg - q_est * 32'(srw_pkg::SEG_BYTES));
                done_next  = 1'b1;
                stage_next = D_IDLE;
            end
            default: stage_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy = stage_reg != D_IDLE;
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// File: hdl/srw_front.sv
`default_nettype none
// Accepts items and register writes, classifies arrivals, queues commands
module srw_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire srw_pkg::in_t     item,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [31:0]      cfg_data,
    output logic                  cmd_valid,
    output srw_pkg::cmd_t         cmd,
    input  wire logic             cmd_pop,
    output srw_pkg::cfg_t         cfg
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CFG  = 2'd1;
    localparam logic [1:0] F_ARR  = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [srw_pkg::FRAME_W-1:0]      last_reg, last_next;
    logic [srw_pkg::LEN_W-1:0]        last_len_reg, last_len_next;
    logic [31:0]                      timeout_reg, timeout_next;
    logic [srw_pkg::LEN_W-1:0]        len_reg, len_next;

    logic                             div_start, div_busy, div_done;
    logic [31:0]                      div_in, div_quot;
    logic [srw_pkg::REM_W-1:0]        div_rem;

    srw_pkg::cmd_t                    q_mem [2];
    logic                             q_wp_reg, q_rp_reg;
    logic [1:0]                       q_cnt_reg;
    logic                             q_push, q_full;
    srw_pkg::cmd_t                    q_in;

    srw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign q_full = q_cnt_reg == 2'd2;
    assign full   = (state_reg != F_IDLE) || q_full || div_busy;
    assign cmd_valid = q_cnt_reg != 2'd0;
    assign cmd       = q_mem[q_rp_reg];
    assign cfg       = '{eof_frame: last_reg, last_len: last_len_reg, timeout: timeout_reg};

    // Control
    always_comb
    begin
        state_next    = state_reg;
        last_next     = last_reg;
        last_len_next = last_len_reg;
        timeout_next  = timeout_reg;
        len_next      = len_reg;
        div_start     = 1'b0;
        div_in        = item.seg_offset;
        q_push        = 1'b0;
        q_in          = '{is_arrival: 1'b0, aligned: 1'b0, frame: '0, length: '0};
        if (cfg_we && cfg_index == srw_pkg::REG_TIMEOUT)
            timeout_next = cfg_data;
        unique case (state_reg)
            F_IDLE:
            begin
                if (cfg_we && cfg_index == srw_pkg::REG_FILE_BYTES)
                begin
                    div_start  = 1'b1;
                    div_in     = cfg_data;
                    state_next = F_CFG;
                end
                else if (push && !full)
                begin
                    if (item.operation == srw_pkg::OP_TICK)
                        q_push = 1'b1;
                    else
                    begin
                        div_start  = 1'b1;
                        len_next   = item.seg_length;
                        state_next = F_ARR;
                    end
                end
            end
            F_CFG:
            begin
                if (div_done)
                begin
                    last_next     = div_quot + 32'(div_rem != '0);
                    last_len_next = (div_rem != '0) ? srw_pkg::LEN_W'(div_rem)
                                                    : srw_pkg::LEN_W'(srw_pkg::SEG_BYTES);
                    state_next    = F_IDLE;
                end
            end
            F_ARR:
            begin
                if (div_done)
                begin
                    q_push     = 1'b1;
                    q_in       = '{is_arrival: 1'b1, aligned: div_rem == '0,
                                   frame: div_quot + 32'd1, length: len_reg};
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            last_reg     <= '0;
            last_len_reg <= '0;
            timeout_reg  <= 32'd1000;
            q_wp_reg     <= 1'b0;
            q_rp_reg     <= 1'b0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            last_len_reg <= last_len_next;
            timeout_reg  <= timeout_next;
            if (q_push)
                q_wp_reg <= ~q_wp_reg;
            if (cmd_pop)
                q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + 2'(q_push) - 2'(cmd_pop);
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (q_push)
            q_mem[q_wp_reg] <= q_in;
    end
endmodule
`default_nettype wire

// File: hdl/srw_back.sv
`default_nettype none
// Window state: timeout scan, arrival marking, in-order delivery, new requests
module srw_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire srw_pkg::cmd_t    cmd,
    output logic                  cmd_pop,
    input  wire srw_pkg::cfg_t    cfg,
    output logic                  empty,
    input  wire logic             pop,
    output srw_pkg::out_t         result
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_RESEND = 3'd3;
    localparam logic [2:0] S_DELIV  = 3'd4;
    localparam logic [2:0] S_REQ    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    localparam int unsigned FW = srw_pkg::FRAME_W;
    localparam int unsigned SW = srw_pkg::SLOT_W;
    localparam int unsigned LW = srw_pkg::LEN_W;

    typedef struct packed {
        logic [1:0]     kind;
        logic [FW-1:0]  frame;
        logic [LW-1:0]  len;
        logic           done;
    } pend_t;

    logic [2:0]             state_reg, state_next;
    logic [FW-1:0]          fd_reg, fd_next;
    logic [FW:0]            ntr_reg, ntr_next;
    logic [srw_pkg::SLOTS-1:0] req_reg, req_next, rcv_reg, rcv_next;
    logic [31:0]            now_reg, now_next;
    logic [SW-1:0]          scan_reg, scan_next;
    logic                   found_reg, found_next;
    logic [FW-1:0]          best_reg, best_next;
    logic [31:0]            age_reg, age_next;
    logic                   pv_reg, pv_next;
    logic [FW-1:0]          pf_reg, pf_next;
    pend_t                  pend_reg, pend_next;
    logic                   pend_v_reg, pend_v_next;
    logic [6:0]             run_cnt_reg, run_cnt_next;

    logic [31:0]            sent_mem [srw_pkg::SLOTS];
    logic [31:0]            sent_rd_reg;
    logic [SW-1:0]          rd_addr, wr_addr;
    logic                   wr_en;

    srw_pkg::out_t          of_mem [4];
    logic [1:0]             of_wp_reg, of_rp_reg;
    logic [2:0]             of_cnt_reg;
    logic                   of_full, of_push, of_pop;
    srw_pkg::out_t          of_in;

    logic                   em_v, emit_ok;
    pend_t                  em;
    logic                   fin_push;
    logic [FW-1:0]          f_scan, f_del, push_frame;
    logic [31:0]            age;
    logic [FW:0]            last_x;
    pend_t                  push_src;
    logic                   push_last;

    function automatic logic [LW-1:0] len_of(input logic [FW-1:0] f,
                                             input srw_pkg::cfg_t c);
        if (f == c.eof_frame && c.eof_frame != '0)
            return c.last_len;
        return LW'(srw_pkg::SEG_BYTES);
    endfunction

    assign of_full = of_cnt_reg == 3'd4;
    assign empty   = of_cnt_reg == 3'd0;
    assign of_pop  = pop && !empty;
    assign result  = of_mem[of_rp_reg];
    assign emit_ok = !pend_v_reg || !of_full;
    assign last_x  = {1'b0, cfg.eof_frame};
    assign f_scan  = fd_reg + 32'd1 + FW'(scan_reg);
    assign f_del   = fd_reg + 32'd1;
    assign age     = now_reg - sent_rd_reg;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        fd_next      = fd_reg;
        ntr_next     = ntr_reg;
        req_next     = req_reg;
        rcv_next     = rcv_reg;
        now_next     = now_reg;
        scan_next    = scan_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        age_next     = age_reg;
        pv_next      = 1'b0;
        pf_next      = pf_reg;
        run_cnt_next = run_cnt_reg;
        cmd_pop      = 1'b0;
        em_v         = 1'b0;
        em           = '{kind: srw_pkg::KIND_REQ, frame: '0, len: '0, done: 1'b0};
        fin_push     = 1'b0;
        rd_addr      = f_scan[SW-1:0];
        wr_en        = 1'b0;
        wr_addr      = ntr_reg[SW-1:0];

        // Age compare for the slot read last cycle; lowest frame wins ties
        if (pv_reg && (!found_reg || age > age_reg))
        begin
            found_next = 1'b1;
            best_next  = pf_reg;
            age_next   = age;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    run_cnt_next = '0;
                    if (!cmd.is_arrival)
                    begin
                        now_next   = now_reg + 32'd1;
                        scan_next  = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        if (cmd.aligned && cmd.frame > fd_reg &&
                            {1'b0, cmd.frame} < ntr_reg && cmd.frame <= cfg.eof_frame)
                        begin
                            if (cmd.length == len_of(cmd.frame, cfg))
                                req_next[cmd.frame[SW-1:0]] = 1'b0;
                            rcv_next[cmd.frame[SW-1:0]] = 1'b1;
                        end
                        state_next = S_DELIV;
                    end
                end
            end
            S_SCAN:
            begin
                pv_next = ({1'b0, f_scan} < ntr_reg) && req_reg[f_scan[SW-1:0]] &&
                          !rcv_reg[f_scan[SW-1:0]];
                pf_next   = f_scan;
                scan_next = scan_reg + SW'(1);
                if (scan_reg == SW'(srw_pkg::SLOTS - 1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_RESEND;
            S_RESEND:
            begin
                if (found_reg && age_reg >= cfg.timeout)
                begin
                    if (emit_ok)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = best_reg[SW-1:0];
                        em_v       = 1'b1;
                        em         = '{kind: srw_pkg::KIND_REQ, frame: best_reg,
                                       len: len_of(best_reg, cfg),
                                       done: fd_reg >= cfg.eof_frame};
                        state_next = S_DELIV;
                    end
                end
                else
                    state_next = S_DELIV;
            end
            S_DELIV:
            begin
                if (fd_reg < cfg.eof_frame && {1'b0, f_del} < ntr_reg &&
                    rcv_reg[f_del[SW-1:0]])
                begin
                    if (emit_ok)
                    begin
                        rcv_next[f_del[SW-1:0]] = 1'b0;
                        req_next[f_del[SW-1:0]] = 1'b0;
                        fd_next = f_del;
                        em_v    = 1'b1;
                        em      = '{kind: srw_pkg::KIND_DELIV, frame: f_del,
                                    len: len_of(f_del, cfg),
                                    done: f_del >= cfg.eof_frame};
                    end
                end
                else
                    state_next = S_REQ;
            end
            S_REQ:
            begin
                // Requests stop at the window edge, the last frame or a full run
                if (ntr_reg <= last_x &&
                    ntr_reg <= {1'b0, fd_reg} + (FW+1)'(srw_pkg::SLOTS) &&
                    run_cnt_reg < 7'(srw_pkg::MAX_RESULTS))
                begin
                    if (emit_ok)
                    begin
                        req_next[ntr_reg[SW-1:0]] = 1'b1;
                        rcv_next[ntr_reg[SW-1:0]] = 1'b0;
                        wr_en    = 1'b1;
                        ntr_next = ntr_reg + (FW+1)'(1);
                        em_v     = 1'b1;
                        em       = '{kind: srw_pkg::KIND_REQ, frame: ntr_reg[FW-1:0],
                                     len: len_of(ntr_reg[FW-1:0], cfg),
                                     done: fd_reg >= cfg.eof_frame};
                    end
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!of_full)
                begin
                    fin_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (em_v)
            run_cnt_next = run_cnt_reg + 7'd1;
    end

    // Pending-result holder: the newest result waits until we know if it is the last
    always_comb
    begin
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        of_push     = 1'b0;
        push_last   = 1'b0;
        push_src    = pend_reg;
        if (em_v)
        begin
            of_push     = pend_v_reg;
            pend_next   = em;
            pend_v_next = 1'b1;
        end
        else if (fin_push)
        begin
            of_push     = 1'b1;
            push_last   = 1'b1;
            pend_v_next = 1'b0;
            if (!pend_v_reg)
                push_src = '{kind: srw_pkg::KIND_IDLE, frame: '0, len: '0,
                             done: fd_reg >= cfg.eof_frame};
        end
        push_frame = push_src.frame - 32'd1;
        of_in.kind          = push_src.kind;
        of_in.frame_offset  = (push_src.kind == srw_pkg::KIND_IDLE) ? 32'd0
                            : 32'(push_frame * 32'(srw_pkg::SEG_BYTES));
        of_in.frame_length  = push_src.len;
        of_in.last_of_run   = push_last;
        of_in.transfer_done = push_src.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fd_reg      <= '0;
            ntr_reg     <= (FW+1)'(1);
            req_reg     <= '0;
            rcv_reg     <= '0;
            now_reg     <= '0;
            scan_reg    <= '0;
            found_reg   <= 1'b0;
            pv_reg      <= 1'b0;
            pend_v_reg  <= 1'b0;
            run_cnt_reg <= '0;
            of_wp_reg   <= '0;
            of_rp_reg   <= '0;
            of_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fd_reg      <= fd_next;
            ntr_reg     <= ntr_next;
            req_reg     <= req_next;
            rcv_reg     <= rcv_next;
            now_reg     <= now_next;
            scan_reg    <= scan_next;
            found_reg   <= found_next;
            pv_reg      <= pv_next;
            pend_v_reg  <= pend_v_next;
            run_cnt_reg <= run_cnt_next;
            if (of_push)
                of_wp_reg <= of_wp_reg + 2'd1;
            if (of_pop)
                of_rp_reg <= of_rp_reg + 2'd1;
            of_cnt_reg <= of_cnt_reg + 3'(of_push) - 3'(of_pop);
        end
    end

    // Payload registers, send-time memory and result queue storage
    always_ff @(posedge clk)
    begin
        best_reg    <= best_next;
        age_reg     <= age_next;
        pf_reg      <= pf_next;
        pend_reg    <= pend_next;
        sent_rd_reg <= sent_mem[rd_addr];
        if (wr_en)
            sent_mem[wr_addr] <= now_reg;
        if (of_push)
            of_mem[of_wp_reg] <= of_in;
    end
endmodule
`default_nettype wire

// File: hdl/selective_repeat_receive_window_top.sv
`default_nettype none
// Selective-repeat receive window. Items enter through a push/full queue port:
// a tick, or a segment arrival with byte offset and length. Results leave through
// an empty/pop queue port: request, in-order delivery, or an idle marker, with
// last_of_run on the final result of each item. An arrival passes through the
// reciprocal divide-by-segment unit before it enters the command queue; a tick
// goes straight into it. A tick then runs the 32-slot oldest-request scan and
// the resend check. Deliveries and then requests follow while the four-entry
// result queue has room; a step ends the deliveries, one ends the requests and
// a last one closes the run. A write of file_bytes keeps full high until its
// divide is done.
module selective_repeat_receive_window_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire srw_pkg::in_t     item,
    output logic                  empty,
    input  wire logic             pop,
    output srw_pkg::out_t         result,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [31:0]      cfg_data
);
    logic            cmd_valid, cmd_pop;
    srw_pkg::cmd_t   cmd;
    srw_pkg::cfg_t   cfg;

    srw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg)
    );

    srw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );
endmodule
`default_nettype wire

// File: hdl/srw_checker.sv
`default_nettype none
module srw_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             empty,
    input  wire logic             pop,
    input  wire srw_pkg::out_t    result
);
    // No undefined result kind
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.kind != 2'd3)
        else $error("undefined result kind");

    // Idle marker always closes a run
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == srw_pkg::KIND_IDLE) |-> result.last_of_run)
        else $error("idle marker without last_of_run");

    // Idle marker carries no frame
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == srw_pkg::KIND_IDLE) |->
            (result.frame_offset == 32'd0 && result.frame_length == '0))
        else $error("idle marker with frame data");

    // Waiting result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");
endmodule

bind selective_repeat_receive_window_top srw_checker u_chk (.*);
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    srw_pkg::in_t item;
    logic empty;
    logic pop;
    srw_pkg::out_t result;
    logic cfg_we;
    logic cfg_index;
    logic [31:0] cfg_data;

    selective_repeat_receive_window_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Window state mirror
    logic [31:0] win_file_bytes;
    logic [31:0] win_timeout;
    logic [31:0] win_delivered;
    logic [32:0] win_next_req;
    logic        win_requested [srw_pkg::SLOTS];
    logic        win_received [srw_pkg::SLOTS];
    logic [31:0] win_sent_at [srw_pkg::SLOTS];
    logic [31:0] win_tick;

    srw_pkg::out_t pending_results [$];
    srw_pkg::in_t  item_queue [$];
    int   errors;
    int   beats_out;
    int   deliveries_seen;
    int   run_count;
    longint cycle_count;
    int   push_gap;
    int   pop_gap;

    function automatic logic [32:0] last_frame_of();
        logic [33:0] sum;
        sum = {2'b0, win_file_bytes} + srw_pkg::SEG_BYTES - 1;
        return 33'(sum / srw_pkg::SEG_BYTES);
    endfunction

    function automatic logic [9:0] frame_len_of(logic [32:0] f);
        logic [32:0] last;
        logic [63:0] base;
        last = last_frame_of();
        if (f == last && last > 0)
        begin
            base = 64'(last - 1) * srw_pkg::SEG_BYTES;
            return 10'(64'(win_file_bytes) - base);
        end
        return 10'(srw_pkg::SEG_BYTES);
    endfunction

    function automatic void queue_item(srw_pkg::in_t it);
        item_queue.insert(item_queue.size(), it);
    endfunction

    function automatic void add_result(logic [1:0] k, logic [32:0] f);
        srw_pkg::out_t r;
        logic [63:0] offs;
        if (run_count >= srw_pkg::MAX_RESULTS)
            return;
        offs = 64'(f - 1) * srw_pkg::SEG_BYTES;
        r.kind = k;
        r.frame_offset = (k == srw_pkg::KIND_IDLE) ? 32'd0 : offs[31:0];
        r.frame_length = (k == srw_pkg::KIND_IDLE) ? 10'd0 : frame_len_of(f);
        r.last_of_run = 1'b0;
        r.transfer_done = (33'(win_delivered) >= last_frame_of());
        pending_results.insert(pending_results.size(), r);
        run_count++;
    endfunction

    // Predict results of one accepted item
    function automatic void predict_window(srw_pkg::in_t it);
        logic [32:0] f;
        logic [32:0] best;
        logic [31:0] age;
        logic [31:0] best_age;
        logic [32:0] last;
        bit found;
        int s;
        run_count = 0;
        if (it.operation == srw_pkg::OP_TICK)
        begin
            found = 0;
            best = 0;
            best_age = 0;
            win_tick = win_tick + 1;
            for (f = 33'(win_delivered) + 1; f < win_next_req; f++)
            begin
                s = int'(f % srw_pkg::SLOTS);
                if (win_requested[s] && !win_received[s])
                begin
                    age = win_tick - win_sent_at[s];
                    if (!found || age > best_age)
                    begin
                        found = 1;
                        best = f;
                        best_age = age;
                    end
                end
            end
            if (found && best_age >= win_timeout)
            begin
                win_sent_at[int'(best % srw_pkg::SLOTS)] = win_tick;
                add_result(srw_pkg::KIND_REQ, best);
            end
        end
        else if (it.seg_offset % srw_pkg::SEG_BYTES == 0)
        begin
            f = 33'(it.seg_offset / srw_pkg::SEG_BYTES) + 1;
            if (!(f <= 33'(win_delivered) || f >= win_next_req || f > last_frame_of()))
            begin
                s = int'(f % srw_pkg::SLOTS);
                if (it.seg_length == frame_len_of(f))
                    win_requested[s] = 0;
                win_received[s] = 1;
            end
        end
        // In-order delivery
        last = last_frame_of();
        while (33'(win_delivered) < last)
        begin
            f = 33'(win_delivered) + 1;
            s = int'(f % srw_pkg::SLOTS);
            if (f >= win_next_req || !win_received[s])
                break;
            win_received[s] = 0;
            win_requested[s] = 0;
            win_delivered = f[31:0];
            add_result(srw_pkg::KIND_DELIV, f);
        end
        // New requests up to window edge
        while (win_next_req <= last && win_next_req <= 33'(win_delivered) + srw_pkg::SLOTS
               && run_count < srw_pkg::MAX_RESULTS)
        begin
            s = int'(win_next_req % srw_pkg::SLOTS);
            win_requested[s] = 1;
            win_received[s] = 0;
            win_sent_at[s] = win_tick;
            add_result(srw_pkg::KIND_REQ, win_next_req);
            win_next_req = win_next_req + 1;
        end
        if (run_count == 0)
            add_result(srw_pkg::KIND_IDLE, 0);
        pending_results[pending_results.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 3);
        return 0;
    endfunction

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
            push_gap <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_window(item);
                void'(item_queue.pop_front());
            end
            if (push && full)
            begin
                // hold the beat
            end
            else if (push_gap > 0)
            begin
                push <= 1'b0;
                push_gap <= push_gap - 1;
            end
            else if (item_queue.size() > 0)
            begin
                push <= 1'b1;
                item <= item_queue[0];
                push_gap <= pick_gap();
            end
            else
                push <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                beats_out <= beats_out + 1;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat kind=%0d", result.kind);
                    errors = errors + 1;
                end
                else
                begin
                    if (result.kind != pending_results[0].kind) begin
                        $error("kind exp %0d got %0d", pending_results[0].kind, result.kind);
                        errors = errors + 1; end
                    if (result.frame_offset != pending_results[0].frame_offset) begin
                        $error("frame_offset exp %0d got %0d",
                               pending_results[0].frame_offset, result.frame_offset);
                        errors = errors + 1; end
                    if (result.frame_length != pending_results[0].frame_length) begin
                        $error("frame_length exp %0d got %0d",
                               pending_results[0].frame_length, result.frame_length);
                        errors = errors + 1; end
                    if (result.last_of_run != pending_results[0].last_of_run) begin
                        $error("last_of_run exp %0d got %0d",
                               pending_results[0].last_of_run, result.last_of_run);
                        errors = errors + 1; end
                    if (result.transfer_done != pending_results[0].transfer_done) begin
                        $error("transfer_done exp %0d got %0d",
                               pending_results[0].transfer_done, result.transfer_done);
                        errors = errors + 1; end
                    if (pending_results[0].kind == srw_pkg::KIND_DELIV)
                        deliveries_seen <= deliveries_seen + 1;
                    void'(pending_results.pop_front());
                end
            end
            if (pop_gap > 0)
            begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else
            begin
                pop <= 1'b1;
                pop_gap <= pick_gap();
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 20000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == srw_pkg::REG_FILE_BYTES)
            win_file_bytes = val;
        else
            win_timeout = val;
        // divider busy after a size write
        repeat (40) @(posedge clk);
    endtask

    task automatic drain_window();
        while (item_queue.size() > 0 || push || pending_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic srw_pkg::in_t tick_item();
        srw_pkg::in_t t;
        t = '0;
        t.operation = srw_pkg::OP_TICK;
        t.seg_offset = $urandom;
        t.seg_length = 10'($urandom);
        return t;
    endfunction

    function automatic srw_pkg::in_t arrive_item(logic [31:0] offs, logic [9:0] len);
        srw_pkg::in_t t;
        t.operation = srw_pkg::OP_ARRIVE;
        t.seg_offset = offs;
        t.seg_length = len;
        return t;
    endfunction

    // Random arrival, mostly for frames in the window
    function automatic srw_pkg::in_t random_arrival();
        logic [32:0] f;
        logic [32:0] span;
        int r;
        r = $urandom_range(0, 9);
        if (r < 7 && win_next_req > 33'(win_delivered) + 1)
        begin
            span = win_next_req - 33'(win_delivered) - 1;
            f = 33'(win_delivered) + 1 + 33'($urandom_range(0, int'(span) - 1));
            return arrive_item(32'(64'(f - 1) * srw_pkg::SEG_BYTES),
                               ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1000))
                                                           : frame_len_of(f));
        end
        if (r == 7)
            return arrive_item($urandom, 10'($urandom));
        return arrive_item(32'($urandom_range(0, 200)) * srw_pkg::SEG_BYTES + (r == 8 ? 1 : 0),
                           10'(srw_pkg::SEG_BYTES));
    endfunction

    task automatic run_phase(logic [31:0] fbytes, logic [31:0] tmo, int n, int tick_pct);
        int i;
        write_reg(srw_pkg::REG_FILE_BYTES, fbytes);
        write_reg(srw_pkg::REG_TIMEOUT, tmo);
        for (i = 0; i < n; i++)
        begin
            // predictions lag pushes; generate against current mirror state
            while (item_queue.size() > 0)
                @(posedge clk);
            if ($urandom_range(0, 99) < tick_pct)
                queue_item(tick_item());
            else
                queue_item(random_arrival());
        end
        drain_window();
    endtask

    initial
    begin
        errors = 0;
        beats_out = 0;
        deliveries_seen = 0;
        run_count = 0;
        cycle_count = 0;
        cfg_we = 1'b0;
        cfg_index = srw_pkg::REG_FILE_BYTES;
        cfg_data = '0;
        win_file_bytes = 0;
        win_timeout = 1000;
        win_delivered = 0;
        win_next_req = 1;
        win_tick = 0;
        for (int s = 0; s < srw_pkg::SLOTS; s++)
        begin
            win_requested[s] = 0;
            win_received[s] = 0;
            win_sent_at[s] = 0;
        end
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty file, then window fill, timeouts and edge arrivals
        queue_item(tick_item());
        queue_item(arrive_item(32'hFFFF_FFFF, 10'h3FF));
        drain_window();
        write_reg(srw_pkg::REG_TIMEOUT, 0);
        write_reg(srw_pkg::REG_FILE_BYTES, 40500);
        queue_item(tick_item());
        queue_item(tick_item());
        queue_item(arrive_item(0, 10'd1000));
        queue_item(arrive_item(1000, 10'd5));
        queue_item(arrive_item(2001, 10'd1000));
        queue_item(arrive_item(0, 10'd1000));
        queue_item(arrive_item(39000, 10'd1000));
        queue_item(arrive_item(40000, 10'd500));
        queue_item(tick_item());
        queue_item(arrive_item(32'd4_000_000, 10'd1000));
        drain_window();
        write_reg(srw_pkg::REG_FILE_BYTES, 3000);
        queue_item(arrive_item(2000, 10'd1000));
        queue_item(arrive_item(1000, 10'd1000));
        queue_item(tick_item());
        drain_window();

        // Random phases with several settings
        run_phase(32'd120_000, 32'd3, 90, 40);
        run_phase(32'd1, 32'hFFFF_FFFF, 30, 30);
        run_phase(32'd64_999, 32'd1, 90, 50);
        run_phase(32'hFFFF_FFFF, 32'd2, 80, 40);
        run_phase(32'd0, 32'd5, 20, 50);
        run_phase(32'd7_777, 32'd0, 40, 50);

        $display("covered %0d result beats, %0d in-order deliveries over several sizes/timeouts",
                 beats_out, deliveries_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
